// ===== hw/rtl/double_hash_table_engine_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef DOUBLE_HASH_TABLE_ENGINE_TOP_MACROS_SVH
`define DOUBLE_HASH_TABLE_ENGINE_TOP_MACROS_SVH
// Implication checked on every rising clock edge while out of reset.
`define DHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge while out of reset.
`define DHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg
// Types, codes and constants of the double-hashing hash table engine.
// ----------------------------------------------------------------------------
`default_nettype none
package dht_pkg;
    localparam int SLOTS_DEFAULT = 1024;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    // Code 3 is not a request; it passes through with no change to the table.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_DEAD  = 2'd2;

    localparam logic [1:0] CFG_FIRST_MULT  = 2'd0;
    localparam logic [1:0] CFG_SECOND_MULT = 2'd1;
    localparam logic [1:0] CFG_BUCKETS     = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [10:0] entry_total;
    } t_rsp;
endpackage
`default_nettype wire

// ===== hw/rtl/double_hash_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_engine_top
// Requests (kind, key, value) enter on i_req with i_valid/o_stall; an item is
// taken at a clock edge with i_valid high and o_stall low. One result per
// request leaves on o_rsp with o_valid/i_stall.
// The front computes both hashes: a multiply, then a 63-step restoring
// reduction by the bucket count; it takes no new request until its job is queued.
// The back walks the probe path over the slot memories, one probed slot at a
// time (registered read, then evaluate and write), up to bucket_count slots.
// A two-entry queue lets the front hash the next request while the back works.
// After reset the back clears the slot marks, one slot a cycle,
// before it takes a job; configuration writes are accepted at any time.
// While i_stall is high the result holds and the back takes no new job.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data (0 first multiplier,
// 1 second multiplier, 2 bucket count). Write only when the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module double_hash_table_engine_top #(
    parameter int SLOTS = dht_pkg::SLOTS_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire dht_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_stall,
    output dht_pkg::t_rsp      o_rsp,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [30:0]   i_cfg_data
);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int JW = $bits(dht_pkg::t_req) + 2 * IDX_W;

    logic [30:0] r_mult1, r_mult2;
    logic [10:0] r_buckets;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult1   <= 31'd151;
            r_mult2   <= 31'd163;
            r_buckets <= 11'd1021;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dht_pkg::CFG_FIRST_MULT:  r_mult1 <= i_cfg_data;
                dht_pkg::CFG_SECOND_MULT: r_mult2 <= i_cfg_data;
                dht_pkg::CFG_BUCKETS:     r_buckets <= i_cfg_data[10:0];
                default: r_buckets <= r_buckets;
            endcase
        end
    end

    // Bucket count with zero taken as one and saturated to SLOTS.
    logic [IDX_W:0] w_buckets;
    always_comb begin
        if (r_buckets == '0) w_buckets = (IDX_W+1)'(1);
        else if (32'(r_buckets) > SLOTS) w_buckets = (IDX_W+1)'(SLOTS);
        else w_buckets = (IDX_W+1)'(r_buckets);
    end

    logic             f_valid, f_stall, q_valid, q_stall;
    dht_pkg::t_req    f_req, q_req;
    logic [IDX_W-1:0] f_h1, f_step, q_h1, q_step;

    dht_front #(.IDX_W(IDX_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .i_mult1(r_mult1), .i_mult2(r_mult2), .i_buckets(w_buckets),
        .o_job_valid(f_valid), .i_job_stall(f_stall), .o_job_req(f_req),
        .o_job_h1(f_h1), .o_job_step(f_step)
    );

    dht_queue #(.W(JW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .o_stall(f_stall),
        .i_data({f_req, f_h1, f_step}), .o_valid(q_valid), .i_stall(q_stall),
        .o_data({q_req, q_h1, q_step})
    );

    dht_back #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(q_valid),
        .o_job_stall(q_stall), .i_job_req(q_req), .i_job_h1(q_h1),
        .i_job_step(q_step), .i_buckets(w_buckets), .o_valid(o_valid),
        .i_stall(i_stall), .o_rsp(o_rsp)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/dht_front.sv =====
// ----------------------------------------------------------------------------
// dht_front
// Accepts requests, computes both hashes and hands the jobs to a queue.
// ----------------------------------------------------------------------------
`default_nettype none
module dht_front #(
    parameter int IDX_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire dht_pkg::t_req    i_req,
    input  wire logic [30:0]      i_mult1,
    input  wire logic [30:0]      i_mult2,
    input  wire logic [IDX_W:0]   i_buckets,
    output logic                  o_job_valid,
    input  wire logic             i_job_stall,
    output dht_pkg::t_req         o_job_req,
    output logic [IDX_W-1:0]      o_job_h1,
    output logic [IDX_W-1:0]      o_job_step
);
    localparam int PW = 63;
    localparam int SW = PW + IDX_W + 1;
    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_MOD  = 3'd2;
    localparam logic [2:0] F_OUT  = 3'd3;

    logic [2:0]        r_state, n_state;
    dht_pkg::t_req     r_req;
    logic [PW-1:0]     r_p1, r_p2;
    logic [6:0]        r_cnt;
    logic [IDX_W:0]    r_b;

    // Restoring reduction: subtract b shifted left by r_cnt when it fits.
    // The shifted divisor is kept wide enough that no bits fall off the top.
    logic [SW-1:0] w_sh;
    assign w_sh = SW'(r_b) << r_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_MUL;
            F_MUL:  n_state = F_MOD;
            F_MOD:  if (r_cnt == 7'd0) n_state = F_OUT;
            F_OUT:  if (!i_job_stall) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        unique case (r_state)
            F_IDLE: begin
                r_req <= i_req;
                r_b   <= (i_buckets == '0) ? (IDX_W+1)'(1) :
                         ((i_buckets > (IDX_W+1)'(1 << IDX_W)) ?
                          (IDX_W+1)'(1 << IDX_W) : i_buckets);
            end
            F_MUL: begin
                r_p1  <= PW'(r_req.key) * PW'(i_mult1);
                r_p2  <= PW'(r_req.key) * PW'(i_mult2);
                r_cnt <= 7'(PW - 1);
            end
            F_MOD: begin
                if (SW'(r_p1) >= w_sh) r_p1 <= r_p1 - w_sh[PW-1:0];
                if (SW'(r_p2) >= w_sh) r_p2 <= r_p2 - w_sh[PW-1:0];
                if (r_cnt != 7'd0) r_cnt <= r_cnt - 7'd1;
            end
            default: ;
        endcase
    end

    // h2 + 1 may equal b; reduce it.
    logic [IDX_W:0] w_step;
    assign w_step = (IDX_W+1)'(r_p2[IDX_W-1:0]) + (IDX_W+1)'(1);

    assign o_stall     = (r_state != F_IDLE);
    assign o_job_valid = (r_state == F_OUT);
    assign o_job_req   = r_req;
    assign o_job_h1    = r_p1[IDX_W-1:0];
    assign o_job_step  = (w_step == r_b) ? '0 : w_step[IDX_W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/dht_queue.sv =====
// ----------------------------------------------------------------------------
// dht_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module dht_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dht_back.sv =====
// ----------------------------------------------------------------------------
// dht_back
// Walks the probe path over the slot memories and produces one result per job.
// ----------------------------------------------------------------------------
`default_nettype none
module dht_back #(
    parameter int SLOTS = 1024,
    parameter int IDX_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    output logic                  o_job_stall,
    input  wire dht_pkg::t_req    i_job_req,
    input  wire logic [IDX_W-1:0] i_job_h1,
    input  wire logic [IDX_W-1:0] i_job_step,
    input  wire logic [IDX_W:0]   i_buckets,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output dht_pkg::t_rsp         o_rsp
);
    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_READ  = 3'd2;
    localparam logic [2:0] B_EVAL  = 3'd3;
    localparam logic [2:0] B_OUT   = 3'd4;

    logic [31:0] r_key_mem [SLOTS];
    logic [31:0] r_val_mem [SLOTS];
    logic [1:0]  r_mark_mem [SLOTS];

    logic [2:0]       r_state;
    dht_pkg::t_req    r_req;
    logic [IDX_W-1:0] r_pos, r_step;
    logic [IDX_W:0]   r_b, r_att;
    logic [IDX_W:0]   r_live;
    logic [31:0]      r_rd_key, r_rd_val;
    logic [1:0]       r_rd_mark;
    logic             r_found;
    logic [31:0]      r_vout;
    logic [1:0]       r_status;

    logic             w_we_mark, w_we_kv;
    logic [1:0]       w_mark_d;
    logic [IDX_W-1:0] w_waddr;
    logic [IDX_W:0]   w_sum;
    logic             w_hit, w_last;

    assign w_sum  = (IDX_W+1)'(r_pos) + (IDX_W+1)'(r_step);
    assign w_hit  = (r_rd_mark == dht_pkg::MARK_LIVE) && (r_rd_key == r_req.key);
    assign w_last = (r_att + (IDX_W+1)'(1) == r_b);

    always_comb begin
        w_we_mark = 1'b0;
        w_we_kv   = 1'b0;
        w_mark_d  = dht_pkg::MARK_EMPTY;
        w_waddr   = r_pos;
        if (r_state == B_CLEAR) begin
            w_we_mark = 1'b1;
            w_waddr   = r_att[IDX_W-1:0];
        end else if (r_state == B_EVAL) begin
            if (r_req.kind == dht_pkg::KIND_INSERT &&
                r_rd_mark != dht_pkg::MARK_LIVE) begin
                w_we_mark = 1'b1;
                w_we_kv   = 1'b1;
                w_mark_d  = dht_pkg::MARK_LIVE;
            end else if (r_req.kind == dht_pkg::KIND_DELETE && w_hit) begin
                w_we_mark = 1'b1;
                w_mark_d  = dht_pkg::MARK_DEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_mark) r_mark_mem[w_waddr] <= w_mark_d;
        if (w_we_kv) begin
            r_key_mem[w_waddr] <= r_req.key;
            r_val_mem[w_waddr] <= r_req.value;
        end
        r_rd_mark <= r_mark_mem[r_pos];
        r_rd_key  <= r_key_mem[r_pos];
        r_rd_val  <= r_val_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_att   <= '0;
            r_live  <= '0;
        end else begin
            unique case (r_state)
                B_CLEAR: begin
                    r_att <= r_att + (IDX_W+1)'(1);
                    if (r_att == (IDX_W+1)'(SLOTS - 1)) r_state <= B_IDLE;
                end
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_req    <= i_job_req;
                        r_pos    <= i_job_h1;
                        r_step   <= i_job_step;
                        r_b      <= (i_buckets == '0) ? (IDX_W+1)'(1) :
                                    ((i_buckets > (IDX_W+1)'(SLOTS)) ?
                                     (IDX_W+1)'(SLOTS) : i_buckets);
                        r_att    <= '0;
                        r_found  <= 1'b0;
                        r_vout   <= '0;
                        r_status <= (i_job_req.kind == dht_pkg::KIND_INSERT) ?
                                    dht_pkg::STATUS_FULL : dht_pkg::STATUS_DONE;
                        r_state  <= (i_job_req.kind == dht_pkg::KIND_INSERT ||
                                     i_job_req.kind == dht_pkg::KIND_SEARCH ||
                                     i_job_req.kind == dht_pkg::KIND_DELETE) ?
                                    B_READ : B_OUT;
                    end
                end
                B_READ: r_state <= B_EVAL;
                B_EVAL: begin
                    r_pos   <= (w_sum >= r_b) ? IDX_W'(w_sum - r_b) : w_sum[IDX_W-1:0];
                    r_att   <= r_att + (IDX_W+1)'(1);
                    r_state <= w_last ? B_OUT : B_READ;
                    unique case (r_req.kind)
                        dht_pkg::KIND_INSERT: begin
                            if (r_rd_mark != dht_pkg::MARK_LIVE) begin
                                r_live   <= r_live + (IDX_W+1)'(1);
                                r_status <= dht_pkg::STATUS_DONE;
                                r_state  <= B_OUT;
                            end
                        end
                        dht_pkg::KIND_SEARCH: begin
                            if (r_rd_mark == dht_pkg::MARK_EMPTY || w_last) begin
                                r_status <= dht_pkg::STATUS_NOT_FOUND;
                                r_state  <= B_OUT;
                            end
                            if (r_rd_mark == dht_pkg::MARK_EMPTY) begin
                            end else if (w_hit) begin
                                r_found  <= 1'b1;
                                r_vout   <= r_rd_val;
                                r_status <= dht_pkg::STATUS_DONE;
                                r_state  <= B_OUT;
                            end
                        end
                        default: begin
                            if (r_rd_mark == dht_pkg::MARK_EMPTY) begin
                                r_state <= B_OUT;
                                r_status <= r_found ? dht_pkg::STATUS_DONE :
                                            dht_pkg::STATUS_NOT_FOUND;
                            end else begin
                                if (w_hit) begin
                                    r_found <= 1'b1;
                                    if (r_live != '0) r_live <= r_live - (IDX_W+1)'(1);
                                end
                                if (w_last) r_status <= (r_found || w_hit) ?
                                    dht_pkg::STATUS_DONE : dht_pkg::STATUS_NOT_FOUND;
                            end
                        end
                    endcase
                end
                B_OUT: if (!i_stall) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_job_stall       = (r_state != B_IDLE);
    assign o_valid           = (r_state == B_OUT);
    assign o_rsp.found       = r_found;
    assign o_rsp.value_out   = r_vout;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_total = 11'(r_live);
endmodule
`default_nettype wire

// ===== hw/rtl/dht_checker.sv =====
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks of the hash table engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_hash_table_engine_top_macros.svh"
module dht_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_valid,
    input wire logic          i_stall,
    input wire dht_pkg::t_rsp o_rsp
);
    `DHT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_rsp))
    `DHT_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, o_valid && o_rsp.found, o_rsp.status == dht_pkg::STATUS_DONE)
    `DHT_ASSERT_IMP(a_vout_zero, i_clk, i_rst_n, o_valid && !o_rsp.found, o_rsp.value_out == 32'd0)
    `DHT_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, o_rsp.status <= dht_pkg::STATUS_NOT_FOUND)
endmodule

bind double_hash_table_engine_top dht_checker u_dht_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_rsp(o_rsp)
);
`default_nettype wire

// ===== bench/double_hash_table_engine_top_test.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_engine_top_test
// Self-checking bench for the double-hashing hash table engine. A directed
// table runs first, then random insert/search/delete/unused traffic, mostly
// over a small pool of keys, in phases with different multipliers and bucket
// counts. Each random request is predicted by a model of the table kept in the
// bench and each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module double_hash_table_engine_top_test;
    localparam int NSLOTS   = 1024;
    localparam int WD_LIMIT = 20000;
    localparam int HOLD_LEN = 300;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    dht_pkg::t_req i_req;
    logic          o_valid;
    logic          i_stall;
    dht_pkg::t_rsp o_rsp;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [30:0]   i_cfg_data;

    double_hash_table_engine_top #(.SLOTS(NSLOTS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the table and its configuration.
    logic [31:0] tbl_key [NSLOTS];
    logic [31:0] tbl_value [NSLOTS];
    logic [1:0]  tbl_mark [NSLOTS];
    logic [10:0] tbl_live;
    logic [30:0] mult_a;
    logic [30:0] mult_b;
    logic [10:0] buckets_reg;

    dht_pkg::t_rsp rsp_q[$];
    int   errors;
    bit   quiet;
    bit   hold_req;
    int   hold_cnt;
    int   idle_cnt;
    logic [31:0] key_pool [12];

    function automatic int probe(logic [31:0] k, int b, int i);
        longint unsigned h1, h2;
        h1 = (64'(k) * 64'(mult_a)) % 64'(b);
        h2 = (64'(k) * 64'(mult_b)) % 64'(b);
        return int'((h1 + 64'(i) * (h2 + 1)) % 64'(b));
    endfunction

    function automatic dht_pkg::t_rsp table_update(dht_pkg::t_req r);
        dht_pkg::t_rsp o;
        int   b;
        int   s;
        o = '0;
        b = buckets_reg;
        if (b == 0) b = 1;
        if (b > NSLOTS) b = NSLOTS;
        if (r.kind == dht_pkg::KIND_INSERT) begin
            o.status = dht_pkg::STATUS_FULL;
            for (int i = 0; i < b; i++) begin
                s = probe(r.key, b, i);
                if (tbl_mark[s] != dht_pkg::MARK_LIVE) begin
                    tbl_key[s] = r.key;
                    tbl_value[s] = r.value;
                    tbl_mark[s] = dht_pkg::MARK_LIVE;
                    tbl_live++;
                    o.status = dht_pkg::STATUS_DONE;
                    break;
                end
            end
        end else if (r.kind == dht_pkg::KIND_SEARCH) begin
            o.status = dht_pkg::STATUS_NOT_FOUND;
            for (int i = 0; i < b; i++) begin
                s = probe(r.key, b, i);
                if (tbl_mark[s] == dht_pkg::MARK_EMPTY) break;
                if (tbl_mark[s] == dht_pkg::MARK_LIVE && tbl_key[s] == r.key) begin
                    o.found = 1'b1;
                    o.value_out = tbl_value[s];
                    o.status = dht_pkg::STATUS_DONE;
                    break;
                end
            end
        end else if (r.kind == dht_pkg::KIND_DELETE) begin
            for (int i = 0; i < b; i++) begin
                s = probe(r.key, b, i);
                if (tbl_mark[s] == dht_pkg::MARK_EMPTY) break;
                if (tbl_mark[s] == dht_pkg::MARK_LIVE && tbl_key[s] == r.key) begin
                    tbl_mark[s] = dht_pkg::MARK_DEAD;
                    if (tbl_live > 0) tbl_live--;
                    o.found = 1'b1;
                end
            end
            o.status = o.found ? dht_pkg::STATUS_DONE : dht_pkg::STATUS_NOT_FOUND;
        end
        o.entry_total = tbl_live;
        return o;
    endfunction

    task automatic send_item(dht_pkg::t_req r, bit typed, dht_pkg::t_rsp e);
        dht_pkg::t_rsp p;
        i_req <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        p = table_update(r);
        rsp_q.push_back(typed ? e : p);
        if (!quiet && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (rsp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == dht_pkg::CFG_FIRST_MULT) mult_a = data;
        else if (idx == dht_pkg::CFG_SECOND_MULT) mult_b = data;
        else if (idx == dht_pkg::CFG_BUCKETS) buckets_reg = data[10:0];
    endtask

    // Results: check against the oldest prediction, then pick the next stall.
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            if (rsp_q.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, o_rsp);
                errors++;
            end else begin
                dht_pkg::t_rsp e;
                e = rsp_q.pop_front();
                if (o_rsp.found !== e.found) begin
                    $display("%0t: found expected %0d actual %0d", $realtime, e.found,
                             o_rsp.found);
                    errors++;
                end
                if (o_rsp.value_out !== e.value_out) begin
                    $display("%0t: value_out expected %h actual %h", $realtime,
                             e.value_out, o_rsp.value_out);
                    errors++;
                end
                if (o_rsp.status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                             o_rsp.status);
                    errors++;
                end
                if (o_rsp.entry_total !== e.entry_total) begin
                    $display("%0t: entry_total expected %0d actual %0d", $realtime,
                             e.entry_total, o_rsp.entry_total);
                    errors++;
                end
            end
        end
        if (hold_req && hold_cnt == 0) begin
            hold_cnt <= HOLD_LEN;
            hold_req <= 1'b0;
            i_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    typedef struct {
        dht_pkg::t_req req;
        bit            typed;
        dht_pkg::t_rsp rsp;
    } t_row;

    typedef struct {
        logic [30:0] ma;
        logic [30:0] mb;
        logic [30:0] nb;
        int          count;
    } t_phase;

    t_row   rows [14];
    t_phase phases [10];

    initial begin
        dht_pkg::t_req r;
        int   pick;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_cnt = 0;
        idle_cnt = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req <= '0;
        i_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= dht_pkg::CFG_FIRST_MULT;
        i_cfg_data <= '0;
        for (int s = 0; s < NSLOTS; s++) begin
            tbl_key[s] = '0;
            tbl_value[s] = '0;
            tbl_mark[s] = dht_pkg::MARK_EMPTY;
        end
        tbl_live = '0;
        mult_a = 31'd151;
        mult_b = 31'd163;
        buckets_reg = 11'd1021;

        // Directed rows run under the reset configuration.
        rows[0]  = '{'{dht_pkg::KIND_SEARCH, 32'd5, 32'd0}, 1,
                     '{1'b0, 32'd0, dht_pkg::STATUS_NOT_FOUND, 11'd0}};
        rows[1]  = '{'{dht_pkg::KIND_DELETE, 32'd5, 32'd0}, 1,
                     '{1'b0, 32'd0, dht_pkg::STATUS_NOT_FOUND, 11'd0}};
        rows[2]  = '{'{dht_pkg::KIND_UNUSED, 32'd0, 32'hFFFFFFFF}, 1,
                     '{1'b0, 32'd0, dht_pkg::STATUS_DONE, 11'd0}};
        rows[3]  = '{'{dht_pkg::KIND_INSERT, 32'd0, 32'hFFFFFFFF}, 1,
                     '{1'b0, 32'd0, dht_pkg::STATUS_DONE, 11'd1}};
        rows[4]  = '{'{dht_pkg::KIND_SEARCH, 32'd0, 32'd0}, 1,
                     '{1'b1, 32'hFFFFFFFF, dht_pkg::STATUS_DONE, 11'd1}};
        rows[5]  = '{'{dht_pkg::KIND_INSERT, 32'hFFFFFFFF, 32'd0}, 1,
                     '{1'b0, 32'd0, dht_pkg::STATUS_DONE, 11'd2}};
        rows[6]  = '{'{dht_pkg::KIND_SEARCH, 32'hFFFFFFFF, 32'd7}, 1,
                     '{1'b1, 32'd0, dht_pkg::STATUS_DONE, 11'd2}};
        rows[7]  = '{'{dht_pkg::KIND_INSERT, 32'd0, 32'h12345678}, 1,
                     '{1'b0, 32'd0, dht_pkg::STATUS_DONE, 11'd3}};
        // A delete removes both copies of the duplicated key.
        rows[8]  = '{'{dht_pkg::KIND_DELETE, 32'd0, 32'd0}, 1,
                     '{1'b1, 32'd0, dht_pkg::STATUS_DONE, 11'd1}};
        rows[9]  = '{'{dht_pkg::KIND_SEARCH, 32'd0, 32'd0}, 1,
                     '{1'b0, 32'd0, dht_pkg::STATUS_NOT_FOUND, 11'd1}};
        rows[10] = '{'{dht_pkg::KIND_INSERT, 32'd0, 32'hA5A5A5A5}, 0, '0};
        rows[11] = '{'{dht_pkg::KIND_SEARCH, 32'd0, 32'd0}, 0, '0};
        rows[12] = '{'{dht_pkg::KIND_UNUSED, 32'hFFFFFFFF, 32'h5A5A5A5A}, 0, '0};
        rows[13] = '{'{dht_pkg::KIND_DELETE, 32'hFFFFFFFF, 32'd0}, 0, '0};

        phases[0] = '{31'd151, 31'd163, 31'd1021, 20};
        phases[1] = '{31'd1, 31'h7FFFFFFF, 31'd1, 40};
        phases[2] = '{31'd0, 31'd5, 31'd7, 80};
        phases[3] = '{31'd3, 31'd0, 31'd13, 100};
        phases[4] = '{31'($urandom), 31'($urandom), 31'd2, 60};
        phases[5] = '{31'h7FFFFFFF, 31'd1, 31'd1024, 20};
        phases[6] = '{31'd17, 31'd29, 31'd0, 30};
        phases[7] = '{31'd5, 31'd7, 31'd2047, 15};
        phases[8] = '{31'($urandom), 31'($urandom), 31'd31, 150};
        phases[9] = '{31'($urandom), 31'($urandom), 31'd11, 135};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[n]) send_item(rows[n].req, rows[n].typed, rows[n].rsp);

        foreach (phases[p]) begin
            drain();
            repeat (20) @(posedge i_clk);
            write_reg(dht_pkg::CFG_FIRST_MULT, phases[p].ma);
            write_reg(dht_pkg::CFG_SECOND_MULT, phases[p].mb);
            write_reg(dht_pkg::CFG_BUCKETS, phases[p].nb);
            quiet = (p == 8);
            key_pool[0] = 32'd0;
            key_pool[1] = 32'hFFFFFFFF;
            for (int k = 2; k < 12; k++) key_pool[k] = $urandom;
            for (int n = 0; n < phases[p].count; n++) begin
                if (p == 3 && n == 10) hold_req = 1'b1;
                // Let the engine empty out completely once in mid-phase.
                if (p == 4 && n == 30) begin
                    drain();
                    @(posedge i_clk);
                end
                pick = $urandom_range(99);
                if (pick < 40) r.kind = dht_pkg::KIND_INSERT;
                else if (pick < 72) r.kind = dht_pkg::KIND_SEARCH;
                else if (pick < 92) r.kind = dht_pkg::KIND_DELETE;
                else r.kind = dht_pkg::KIND_UNUSED;
                r.key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(11)];
                r.value = $urandom;
                send_item(r, 1'b0, '0);
            end
        end
        quiet = 1'b0;
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dht_pkg.sv
hw/rtl/dht_front.sv
hw/rtl/dht_queue.sv
hw/rtl/dht_back.sv
hw/rtl/double_hash_table_engine_top.sv
hw/rtl/dht_checker.sv
bench/double_hash_table_engine_top_test.sv
